// ===== sv/msss_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked byte signature scan package
// Shared widths, defaults, opcodes and the hold bundle that the queue and
// the result drain hand to the front end.
// ----------------------------------------------------------------------------
package msss_pkg;

   // Default sizes of the signature store and the byte counter.
   localparam int NUM_PATTERNS_DEF = 8;
   localparam int MAX_LEN_DEF      = 16;
   localparam int ADDR_WIDTH_DEF   = 32;

   // At most this many matches are reported for one scanned byte.
   localparam int MAX_RESULTS = 8;
   localparam int RCNT_W      = $clog2(MAX_RESULTS);

   // Entries in the match queue between front end and drain.
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths of the request and response beats.
   localparam int OPCODE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int SEL_W    = 3;
   localparam int POS_W    = 4;
   localparam int LEN_W    = 5;
   localparam int OFFSET_W = 16;
   localparam int PID_W    = 3;
   localparam int MADDR_W  = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SCAN       = 2'd0,
      OP_WRITE_BYTE = 2'd1,
      OP_SET_LENGTH = 2'd2,
      OP_RESTART    = 2'd3
   } op_type;

   // Back pressure seen by the front end.
   typedef struct packed {
      logic queue_full;
      logic drain_busy;
   } msss_hold_type;

endpackage

// ===== sv/msss_chan_if.sv =====
// ----------------------------------------------------------------------------
// Masked byte signature scan channels
// Valid/ready channels for request beats and for match report beats.
// ----------------------------------------------------------------------------
interface msss_req_if;
   logic                           valid;
   logic                           ready;
   logic [msss_pkg::OPCODE_W-1:0]  opcode;
   logic [msss_pkg::BYTE_W-1:0]    byte_value;
   logic [msss_pkg::BYTE_W-1:0]    mask_value;
   logic [msss_pkg::SEL_W-1:0]     pattern_sel;
   logic [msss_pkg::POS_W-1:0]     position;
   logic [msss_pkg::LEN_W-1:0]     length_value;
   logic [msss_pkg::OFFSET_W-1:0]  offset_value;

   modport source (
      output valid, opcode, byte_value, mask_value, pattern_sel, position,
             length_value, offset_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, byte_value, mask_value, pattern_sel, position,
             length_value, offset_value,
      output ready
   );
endinterface

interface msss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [msss_pkg::PID_W-1:0]    pattern_id;
   logic [msss_pkg::MADDR_W-1:0]  match_address;
   logic                          last;

   modport source (
      output valid, pattern_id, match_address, last,
      input  ready
   );
   modport sink (
      input  valid, pattern_id, match_address, last,
      output ready
   );
endinterface

// ===== sv/masked_byte_signature_scan_unit.sv =====
// ----------------------------------------------------------------------------
// Masked byte signature scan unit
// Path: a scanned byte's matches pass the match queue, the drain's hit register
//   and the response register to rsp_bus, one a cycle while rsp_bus is ready.
// Throughput: one request beat per cycle while req_bus.ready is high, one match
//   beat per cycle while rsp_bus is ready; the match queue absorbs hit bytes.
// Reset: synchronous; clears signature masks, lengths, offsets, history and queue.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan_unit #(
   parameter int NUM_PATTERNS = msss_pkg::NUM_PATTERNS_DEF,
   parameter int MAX_LEN      = msss_pkg::MAX_LEN_DEF,
   parameter int ADDR_WIDTH   = msss_pkg::ADDR_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   msss_req_if.sink    req_bus,
   msss_rsp_if.source  rsp_bus
);

   // One queue entry is the hit vector of a scanned byte together with the
   // byte count at that byte; the address is formed later in the drain.
   localparam int ENTRY_W = ADDR_WIDTH + NUM_PATTERNS;

   msss_pkg::msss_hold_type hold;

   logic                    push;
   logic [NUM_PATTERNS-1:0] push_hits;
   logic [ADDR_WIDTH-1:0]   push_seen;
   logic [NUM_PATTERNS-1:0][msss_pkg::OFFSET_W-1:0] offsets;

   logic               pop;
   logic               q_valid;
   logic               q_full;
   logic [ENTRY_W-1:0] q_data;
   logic               drain_busy;

   // The front end stalls when the queue is full. It also holds back a
   // length and offset beat while hits are still waiting to be reported,
   // since the drain reads the live offsets when it forms an address.
   assign hold.queue_full = q_full;
   assign hold.drain_busy = q_valid || drain_busy;

   // Front end: decodes every beat, keeps signatures and history, and
   // compares all signature bytes against the history in the accept cycle.
   msss_front #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .MAX_LEN      (MAX_LEN),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .hold      (hold),
      .push      (push),
      .push_hits (push_hits),
      .push_seen (push_seen),
      .offsets   (offsets)
   );

   // Only bytes that hit at least one signature take a queue entry.
   msss_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (msss_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_seen, push_hits}),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .full      (q_full)
   );

   // Drain: walks the hit vector lowest index first, one match per beat,
   // and flags the final match of each byte.
   msss_drain #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_drain (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_hits  (q_data[NUM_PATTERNS-1:0]),
      .q_seen  (q_data[ENTRY_W-1:NUM_PATTERNS]),
      .offsets (offsets),
      .pop     (pop),
      .busy    (drain_busy),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== sv/msss_queue.sv =====
// ----------------------------------------------------------------------------
// Match queue
// Small register FIFO holding one entry per scanned byte that hit.
// ----------------------------------------------------------------------------
module msss_queue #(
   parameter int WIDTH = 40,
   parameter int DEPTH = msss_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             q_valid,
   output logic [WIDTH-1:0] q_data,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         bump = '0;
      end else begin
         bump = ptr + PTR_W'(1);
      end
   endfunction

   assign q_valid = (count_ff != '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("match queue count beyond its depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("match queue lost a pushed entry");

endmodule

// ===== sv/msss_front.sv =====
// ----------------------------------------------------------------------------
// Scan front end
// Decodes request beats, holds the signatures and the byte history, and
// forms the hit vector of every scanned byte.
// ----------------------------------------------------------------------------
module msss_front #(
   parameter int NUM_PATTERNS = msss_pkg::NUM_PATTERNS_DEF,
   parameter int MAX_LEN      = msss_pkg::MAX_LEN_DEF,
   parameter int ADDR_WIDTH   = msss_pkg::ADDR_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   msss_req_if.sink                req_bus,
   input  msss_pkg::msss_hold_type hold,
   output logic                    push,
   output logic [NUM_PATTERNS-1:0] push_hits,
   output logic [ADDR_WIDTH-1:0]   push_seen,
   output logic [NUM_PATTERNS-1:0][msss_pkg::OFFSET_W-1:0] offsets
);

   localparam int HIDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int FILL_W = $clog2(MAX_LEN + 1);
   localparam int CW     = (FILL_W > msss_pkg::LEN_W) ? FILL_W : msss_pkg::LEN_W;

   msss_pkg::op_type op;
   logic accept;
   logic do_scan, do_write, do_len, do_restart;

   logic [msss_pkg::BYTE_W-1:0] pat_byte_ff [NUM_PATTERNS][MAX_LEN];
   logic [msss_pkg::BYTE_W-1:0] pat_byte_in [NUM_PATTERNS][MAX_LEN];
   logic [msss_pkg::BYTE_W-1:0] pat_mask_ff [NUM_PATTERNS][MAX_LEN];
   logic [msss_pkg::BYTE_W-1:0] pat_mask_in [NUM_PATTERNS][MAX_LEN];
   logic [msss_pkg::LEN_W-1:0]  len_ff [NUM_PATTERNS];
   logic [msss_pkg::LEN_W-1:0]  len_in [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0][msss_pkg::OFFSET_W-1:0] off_ff, off_in;

   logic [msss_pkg::BYTE_W-1:0] hist_ff  [MAX_LEN];
   logic [msss_pkg::BYTE_W-1:0] hist_in  [MAX_LEN];
   logic [msss_pkg::BYTE_W-1:0] hist_new [MAX_LEN];
   logic [FILL_W-1:0]           fill_ff, fill_in, fill_new;
   logic [ADDR_WIDTH-1:0]       seen_ff, seen_in, seen_new;

   logic [msss_pkg::LEN_W-1:0]               len_sat;
   logic [NUM_PATTERNS-1:0][MAX_LEN-1:0]     cell_ok;
   logic [NUM_PATTERNS-1:0]                  hits;

   assign op = msss_pkg::op_type'(req_bus.opcode);

   // Offsets feed the drain's address subtract, so they may only change
   // once every queued hit has been reported.
   assign req_bus.ready = !hold.queue_full &&
                          !(op == msss_pkg::OP_SET_LENGTH && hold.drain_busy);
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      do_scan    = 1'b0;
      do_write   = 1'b0;
      do_len     = 1'b0;
      do_restart = 1'b0;
      unique case (op)
         msss_pkg::OP_SCAN:       do_scan    = accept;
         msss_pkg::OP_WRITE_BYTE: do_write   = accept;
         msss_pkg::OP_SET_LENGTH: do_len     = accept;
         msss_pkg::OP_RESTART:    do_restart = accept;
      endcase
   end

   // History as it stands once the incoming byte is shifted in.
   always_comb begin
      hist_new[0] = req_bus.byte_value;
      for (int k = 1; k < MAX_LEN; k++) begin
         hist_new[k] = hist_ff[k-1];
      end
      fill_new = (fill_ff < FILL_W'(MAX_LEN)) ? fill_ff + FILL_W'(1) : fill_ff;
      seen_new = seen_ff + ADDR_WIDTH'(1);
   end

   // Pattern byte k lines up with history tap (length - 1 - k).
   always_comb begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         for (int k = 0; k < MAX_LEN; k++) begin
            cell_ok[p][k] = (k >= int'(len_ff[p])) ||
               (((hist_new[HIDX_W'(int'(len_ff[p]) - 1 - k)] ^ pat_byte_ff[p][k])
                 & pat_mask_ff[p][k]) == '0);
         end
         hits[p] = (len_ff[p] != '0) &&
                   (CW'(len_ff[p]) <= CW'(fill_new)) && (&cell_ok[p]);
      end
   end

   assign push      = do_scan && (hits != '0);
   assign push_hits = hits;
   assign push_seen = seen_new;
   assign offsets   = off_ff;

   assign len_sat = (int'(req_bus.length_value) > MAX_LEN) ?
                    msss_pkg::LEN_W'(MAX_LEN) : req_bus.length_value;

   always_comb begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
         len_in[p] = len_ff[p];
         off_in[p] = off_ff[p];
         if (do_len && int'(req_bus.pattern_sel) == p) begin
            len_in[p] = len_sat;
            off_in[p] = req_bus.offset_value;
         end
         for (int k = 0; k < MAX_LEN; k++) begin
            pat_byte_in[p][k] = pat_byte_ff[p][k];
            pat_mask_in[p][k] = pat_mask_ff[p][k];
            if (do_write && int'(req_bus.pattern_sel) == p &&
                int'(req_bus.position) == k) begin
               pat_byte_in[p][k] = req_bus.byte_value;
               pat_mask_in[p][k] = req_bus.mask_value;
            end
         end
      end
   end

   always_comb begin
      hist_in = hist_ff;
      fill_in = fill_ff;
      seen_in = seen_ff;
      if (do_restart) begin
         for (int k = 0; k < MAX_LEN; k++) begin
            hist_in[k] = '0;
         end
         fill_in = '0;
         seen_in = '0;
      end else if (do_scan) begin
         hist_in = hist_new;
         fill_in = fill_new;
         seen_in = seen_new;
      end
   end

   // A cleared mask matches any byte, so the data bytes need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PATTERNS; p++) begin
            len_ff[p] <= '0;
            off_ff[p] <= '0;
            for (int k = 0; k < MAX_LEN; k++) begin
               pat_mask_ff[p][k] <= '0;
            end
         end
         for (int k = 0; k < MAX_LEN; k++) begin
            hist_ff[k] <= '0;
         end
         fill_ff <= '0;
         seen_ff <= '0;
      end else begin
         len_ff      <= len_in;
         off_ff      <= off_in;
         pat_mask_ff <= pat_mask_in;
         hist_ff     <= hist_in;
         fill_ff     <= fill_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_byte_ff <= pat_byte_in;
   end

endmodule

// ===== sv/msss_drain.sv =====
// ----------------------------------------------------------------------------
// Match drain
// Takes hit vectors from the queue and reports one match per beat, lowest
// pattern first, with its address.
// ----------------------------------------------------------------------------
module msss_drain #(
   parameter int NUM_PATTERNS = msss_pkg::NUM_PATTERNS_DEF,
   parameter int ADDR_WIDTH   = msss_pkg::ADDR_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  logic [NUM_PATTERNS-1:0] q_hits,
   input  logic [ADDR_WIDTH-1:0]   q_seen,
   input  logic [NUM_PATTERNS-1:0][msss_pkg::OFFSET_W-1:0] offsets,
   output logic                    pop,
   output logic                    busy,
   msss_rsp_if.source              rsp_bus
);

   localparam int PIDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int AEXT_W = (ADDR_WIDTH > msss_pkg::MADDR_W) ? ADDR_WIDTH : msss_pkg::MADDR_W;

   logic                          busy_ff, busy_in;
   logic [NUM_PATTERNS-1:0]       mask_ff, mask_in;
   logic [ADDR_WIDTH-1:0]         seen_ff, seen_in;
   logic [msss_pkg::RCNT_W-1:0]   cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [msss_pkg::PID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [msss_pkg::MADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                    advance, emit, is_last, done;
   logic [PIDX_W-1:0]       sel_idx;
   logic [NUM_PATTERNS-1:0] rem;
   logic [ADDR_WIDTH-1:0]   diff;
   logic [AEXT_W-1:0]       addr_ext;

   always_comb begin
      sel_idx = '0;
      for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
         if (mask_ff[p]) begin
            sel_idx = PIDX_W'(p);
         end
      end
   end

   assign rem      = mask_ff & ~(NUM_PATTERNS'(1) << sel_idx);
   assign diff     = seen_ff - ADDR_WIDTH'(offsets[sel_idx]);
   assign addr_ext = AEXT_W'(diff);

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign emit    = busy_ff && advance;
   // The report for a byte stops early once the result limit is reached.
   assign is_last = (rem == '0) ||
                    (cnt_ff == msss_pkg::RCNT_W'(msss_pkg::MAX_RESULTS - 1));
   assign done    = emit && is_last;
   assign pop     = q_valid && (!busy_ff || done);
   assign busy    = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      seen_in = seen_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         busy_in = 1'b1;
         mask_in = q_hits;
         seen_in = q_seen;
         cnt_in  = '0;
      end else if (emit) begin
         busy_in = !is_last;
         mask_in = rem;
         cnt_in  = cnt_ff + msss_pkg::RCNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = msss_pkg::PID_W'(sel_idx);
         rsp_addr_in  = addr_ext[msss_pkg::MADDR_W-1:0];
         rsp_last_in  = is_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      seen_ff     <= seen_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pattern_id    = rsp_id_ff;
   assign rsp_bus.match_address = rsp_addr_ff;
   assign rsp_bus.last          = rsp_last_ff;

   a_busy_has_hit: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> mask_ff != '0)
      else $error("drain busy with no pending hit");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      done && !pop |=> !busy_ff)
      else $error("drain kept working after the final match of a byte");

endmodule
